### sv/wapt_pkg.sv
// Shared types, constants and register indexes for the automatic print trigger.
`timescale 1ns / 1ps

package wapt_pkg;

  localparam int WEIGHT_BITS     = 24;
  localparam int QUALIFY_SAMPLES = 4;
  localparam int QUAL_W          = $clog2(QUALIFY_SAMPLES + 1);
  localparam int THRESH_BITS     = WEIGHT_BITS - 1;
  localparam int CFG_IDX_W       = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINT_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_AMOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRINT_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_CHECK_ON  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_PRINT_ON    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLOCK_ON     = 3'd7;

  // Print status codes
  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_PRINT    = 2'd1;
  localparam logic [1:0] STATUS_BAD_ZERO = 2'd2;

  typedef struct packed {
    logic                          reset_mode;
    logic [THRESH_BITS-1:0]        print_threshold;
    logic signed [WEIGHT_BITS-1:0] rearm_threshold;
    logic [THRESH_BITS-1:0]        deviation_amount;
    logic signed [WEIGHT_BITS-1:0] min_print_weight;
    logic                          motion_check_on;
    logic                          auto_print_on;
    logic                          interlock_on;
  } cfg_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_sample;
    logic                          in_motion;
    logic                          over_capacity;
    logic                          under_zero;
    logic                          expanded_display;
    logic                          legal_for_trade;
    logic                          zero_captured;
    logic                          applet_allows;
  } item_t;

  typedef struct packed {
    logic                          armed;
    logic [QUAL_W-1:0]             qualify_count;
    logic signed [WEIGHT_BITS-1:0] last_printed_weight;
  } trig_state_t;

endpackage

### sv/wapt_decide.sv
// Per-sample decision logic: bad-zero check, re-arm, qualify and print, with the next trigger state.
`timescale 1ns / 1ps

module wapt_decide import wapt_pkg::*; (
  input  cfg_t        cfg,
  input  item_t       item,
  input  trig_state_t cur,
  output trig_state_t nxt,
  output logic [1:0]  status
);

  logic signed [WEIGHT_BITS-1:0] w;
  logic signed [WEIGHT_BITS:0]   diff;
  logic        [WEIGHT_BITS:0]   abs_diff;
  logic signed [WEIGHT_BITS:0]   w_ext;
  logic signed [WEIGHT_BITS:0]   thresh_ext;
  logic                          still_ok;
  logic                          active;
  logic                          rearm_hit;
  logic                          dev_hit;
  logic                          common;
  logic                          qualifies;
  logic [QUAL_W-1:0]             count_inc;

  assign w          = item.weight_sample;
  assign w_ext      = {w[WEIGHT_BITS-1], w};
  assign diff       = w_ext - {cur.last_printed_weight[WEIGHT_BITS-1], cur.last_printed_weight};
  assign abs_diff   = diff[WEIGHT_BITS] ? (~diff + 1'b1) : diff;
  assign thresh_ext = $signed({2'b00, cfg.print_threshold});

  assign still_ok  = !cfg.motion_check_on || !item.in_motion;
  assign active    = cfg.interlock_on || (cfg.auto_print_on && item.applet_allows);
  assign rearm_hit = still_ok && (w < cfg.rearm_threshold);
  assign dev_hit   = still_ok && (abs_diff > {2'b00, cfg.deviation_amount});

  assign common = cfg.auto_print_on && !item.in_motion && !item.over_capacity &&
                  !item.under_zero && !(item.expanded_display && item.legal_for_trade) &&
                  (w > cfg.min_print_weight);

  // Return mode also needs a nonzero print threshold that the weight exceeds
  assign qualifies = cfg.reset_mode ? common
                   : (common && (cfg.print_threshold != '0) && (w_ext > thresh_ext));

  assign count_inc = cur.qualify_count + 1'b1;

  always_comb begin
    nxt    = cur;
    status = STATUS_NONE;
    if (!item.zero_captured) begin
      status = STATUS_BAD_ZERO;
    end else if (active) begin
      if (!cur.armed) begin
        nxt.armed = cfg.reset_mode ? dev_hit : rearm_hit;
      end else if (qualifies) begin
        if (count_inc >= QUAL_W'(QUALIFY_SAMPLES)) begin
          nxt.qualify_count = '0;
          nxt.armed         = 1'b0;
          if (cfg.reset_mode) begin
            nxt.last_printed_weight = w;
          end
          status = STATUS_PRINT;
        end else begin
          nxt.qualify_count = count_inc;
        end
      end else begin
        nxt.qualify_count = '0;
      end
    end
  end

endmodule

### sv/weight_auto_print_trigger_top.sv
// Top level of the automatic print trigger: config registers, sample and result stages.
`timescale 1ns / 1ps

// Automatic print trigger for a weighing scale. Each accepted sample gives
// exactly one print_status result (0 none, 1 print, 2 bad zero) in sample
// order. A sample is registered on acceptance, decided combinationally
// against the trigger state while it waits in the sample register, and moves
// into the result register when that register is free, raising out_valid. One
// sample is taken every cycle while the result side keeps up. Configuration
// writes are always ready and take effect at the next sample decided after
// the write.
module weight_auto_print_trigger_top import wapt_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [WEIGHT_BITS-1:0] in_weight_sample,
  input  logic                          in_in_motion,
  input  logic                          in_over_capacity,
  input  logic                          in_under_zero,
  input  logic                          in_expanded_display,
  input  logic                          in_legal_for_trade,
  input  logic                          in_zero_captured,
  input  logic                          in_applet_allows,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_print_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WEIGHT_BITS-1:0]        cfg_data
);

  cfg_t        cfg_r;
  item_t       item_r;
  logic        item_valid_r;
  trig_state_t state_r;
  trig_state_t state_nxt;
  logic [1:0]  status_nxt;
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        out_free;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = item_valid_r && out_free;
  assign in_ready  = !item_valid_r || out_free;

  // Configuration registers; bits above a register's width are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESET_MODE:       cfg_r.reset_mode       <= cfg_data[0];
        REG_PRINT_THRESHOLD:  cfg_r.print_threshold  <= cfg_data[THRESH_BITS-1:0];
        REG_REARM_THRESHOLD:  cfg_r.rearm_threshold  <= cfg_data;
        REG_DEVIATION_AMOUNT: cfg_r.deviation_amount <= cfg_data[THRESH_BITS-1:0];
        REG_MIN_PRINT_WEIGHT: cfg_r.min_print_weight <= cfg_data;
        REG_MOTION_CHECK_ON:  cfg_r.motion_check_on  <= cfg_data[0];
        REG_AUTO_PRINT_ON:    cfg_r.auto_print_on    <= cfg_data[0];
        REG_INTERLOCK_ON:     cfg_r.interlock_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.weight_sample    <= in_weight_sample;
      item_r.in_motion        <= in_in_motion;
      item_r.over_capacity    <= in_over_capacity;
      item_r.under_zero       <= in_under_zero;
      item_r.expanded_display <= in_expanded_display;
      item_r.legal_for_trade  <= in_legal_for_trade;
      item_r.zero_captured    <= in_zero_captured;
      item_r.applet_allows    <= in_applet_allows;
    end
  end

  wapt_decide u_decide (
    .cfg    (cfg_r),
    .item   (item_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .status (status_nxt)
  );

  // Trigger state advances only when a sample moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_print_status = status_r;

endmodule
